// ===== rtl/rvp_pkg.sv =====
package rvp_pkg;

    // Sine and cosine are held in signed fixed point with this many fraction bits.
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int ANGLE_W        = 9;
    localparam int CFG_ADDR_W     = 2;
    localparam int TABLE_IDX_W    = 7;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PIVOT_X = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PIVOT_Y = 2'd2;

    localparam logic [ANGLE_W-1:0] FULL_TURN      = 9'd360;
    localparam logic [ANGLE_W-1:0] THREE_QUARTERS = 9'd270;
    localparam logic [ANGLE_W-1:0] HALF_TURN      = 9'd180;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN   = 9'd90;
    localparam logic [TABLE_IDX_W-1:0] RIGHT_ANGLE = 7'd90;

    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRAC_BITS);

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_q;
        logic signed [TRIG_W-1:0] cos_q;
    } trig_t;

    // sin(d degrees) * 2^14, rounded half up, for d = 0..90.
    localparam logic [TRIG_W-2:0] SINE_TABLE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    // Folds an angle in degrees onto the first quadrant and builds sine and cosine.
    function automatic trig_t trig_from_angle(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W-1:0]         a;
        logic [ANGLE_W-1:0]         rem;
        logic [1:0]                 quad;
        logic [TABLE_IDX_W-1:0]     r;
        logic signed [TRIG_W-1:0]   sr;
        logic signed [TRIG_W-1:0]   cr;
        trig_t                      t;
        a = (angle >= FULL_TURN) ? angle - FULL_TURN : angle;
        priority if (a >= THREE_QUARTERS)
        begin
            quad = 2'd3;
            rem  = a - THREE_QUARTERS;
        end
        else if (a >= HALF_TURN)
        begin
            quad = 2'd2;
            rem  = a - HALF_TURN;
        end
        else if (a >= QUARTER_TURN)
        begin
            quad = 2'd1;
            rem  = a - QUARTER_TURN;
        end
        else
        begin
            quad = 2'd0;
            rem  = a;
        end
        r  = rem[TABLE_IDX_W-1:0];
        sr = signed'({1'b0, SINE_TABLE[r]});
        cr = signed'({1'b0, SINE_TABLE[RIGHT_ANGLE - r]});
        unique case (quad)
            2'd0:
            begin
                t.sin_q = sr;
                t.cos_q = cr;
            end
            2'd1:
            begin
                t.sin_q = cr;
                t.cos_q = -sr;
            end
            2'd2:
            begin
                t.sin_q = -sr;
                t.cos_q = -cr;
            end
            default:
            begin
                t.sin_q = -cr;
                t.cos_q = sr;
            end
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/rotate_vertices_about_pivot_top.sv =====
// Rotates a stream of 2D integer vertices about a programmable pivot by a
// programmable whole number of degrees, and tracks the bounding box of the
// rotated points of the current shape.
//
// Input channel (s_*): one vertex per transaction; s_tuser carries the flag
// that starts a new shape, which restarts the box at that vertex.
// Output channel (m_*): one transaction per input vertex, in order, with the
// rounded and saturated rotated point and the box including that point.
// Configuration: cfg_we writes cfg_data to register cfg_addr (0 = angle,
// 1 = pivot x, 2 = pivot y); the angle's sine and cosine are looked up at the
// write. Write only while no vertex is in flight.
//
// Throughput is one vertex per cycle while the receiver keeps m_tready high.
// An input transaction passes the input register, multiplier register,
// rounding register and the output register that also holds the box.
// Reset clears the pipeline, the box to (0,0)-(0,0), the angle to zero and
// the pivot to the origin. When the receiver holds m_tready low, the result
// waits in the output register and the three stages behind it keep filling;
// s_tready drops only once all of them are occupied.
module rotate_vertices_about_pivot_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [rvp_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [((COORD_BITS > 9) ? COORD_BITS : 9)-1:0] cfg_data,
    // Vertex input.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata from bit 0: vertex_x, vertex_y, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // s_tuser from bit 0: first_of_shape.
    input  logic [0:0]                             s_tuser,
    // Result output.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata from bit 0: rotated_x, rotated_y, left_edge, top_edge,
    // right_edge, bottom_edge, zero fill.
    output logic [((6*COORD_BITS+7)/8)*8-1:0]      m_tdata
);

    localparam int M_W = ((6*COORD_BITS+7)/8)*8;

    rvp_pkg::trig_t               trig_reg;
    logic signed [COORD_BITS-1:0] pivot_x_reg, pivot_y_reg;

    logic                         rot_valid, rot_ready, rot_first;
    logic signed [COORD_BITS-1:0] rot_x, rot_y;

    logic                         m_valid_reg;
    logic signed [COORD_BITS-1:0] rx_out_reg, ry_out_reg;
    logic signed [COORD_BITS-1:0] box_min_x_reg, box_min_y_reg;
    logic signed [COORD_BITS-1:0] box_max_x_reg, box_max_y_reg;
    logic signed [COORD_BITS-1:0] box_min_x_next, box_min_y_next;
    logic signed [COORD_BITS-1:0] box_max_x_next, box_max_y_next;
    logic                         load;

    // Configuration registers. The angle is kept only as its sine and cosine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg.sin_q <= '0;
            trig_reg.cos_q <= rvp_pkg::TRIG_ONE;
            pivot_x_reg    <= '0;
            pivot_y_reg    <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == rvp_pkg::REG_ANGLE)
                trig_reg <= rvp_pkg::trig_from_angle(cfg_data[rvp_pkg::ANGLE_W-1:0]);
            if (cfg_addr == rvp_pkg::REG_PIVOT_X)
                pivot_x_reg <= cfg_data[COORD_BITS-1:0];
            if (cfg_addr == rvp_pkg::REG_PIVOT_Y)
                pivot_y_reg <= cfg_data[COORD_BITS-1:0];
        end
    end

    rvp_rotate #(
        .COORD_BITS (COORD_BITS)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vertex_x  (s_tdata[COORD_BITS-1:0]),
        .vertex_y  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .first_in  (s_tuser[0]),
        .trig      (trig_reg),
        .pivot_x   (pivot_x_reg),
        .pivot_y   (pivot_y_reg),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .first_out (rot_first)
    );

    // The output register takes a new point whenever it is empty or being drained.
    assign rot_ready = !m_valid_reg || m_tready;
    assign load      = rot_valid && rot_ready;

    // A shape start restarts the box at this point; otherwise the box grows to include it.
    always_comb
    begin
        if (rot_first)
        begin
            box_min_x_next = rot_x;
            box_max_x_next = rot_x;
            box_min_y_next = rot_y;
            box_max_y_next = rot_y;
        end
        else
        begin
            box_min_x_next = (rot_x < box_min_x_reg) ? rot_x : box_min_x_reg;
            box_max_x_next = (rot_x > box_max_x_reg) ? rot_x : box_max_x_reg;
            box_min_y_next = (rot_y < box_min_y_reg) ? rot_y : box_min_y_reg;
            box_max_y_next = (rot_y > box_max_y_reg) ? rot_y : box_max_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            box_min_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
        end
        else
        begin
            if (rot_ready)
                m_valid_reg <= rot_valid;
            if (load)
            begin
                box_min_x_reg <= box_min_x_next;
                box_min_y_reg <= box_min_y_next;
                box_max_x_reg <= box_max_x_next;
                box_max_y_reg <= box_max_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rx_out_reg <= rot_x;
            ry_out_reg <= rot_y;
        end
    end

    // The box registers hold the box after the point in the output register.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_W'({box_max_y_reg, box_max_x_reg, box_min_y_reg, box_min_x_reg,
                            ry_out_reg, rx_out_reg});

endmodule

// ===== rtl/rvp_rotate.sv =====
module rvp_rotate #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] vertex_x,
    input  logic signed [COORD_BITS-1:0] vertex_y,
    input  logic                         first_in,
    input  rvp_pkg::trig_t               trig,
    input  logic signed [COORD_BITS-1:0] pivot_x,
    input  logic signed [COORD_BITS-1:0] pivot_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] rot_x,
    output logic signed [COORD_BITS-1:0] rot_y,
    output logic                         first_out
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = COORD_BITS + 1 + rvp_pkg::TRIG_W;
    localparam int SUM_W  = PROD_W + 1 + 1;
    localparam int HALF   = 1 << (rvp_pkg::TRIG_FRAC_BITS - 1);

    // Rounds a Q.TRIG_FRAC_BITS total half away from zero and clamps to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] round_sat(
        input logic signed [SUM_W-1:0] num
    );
        logic signed [SUM_W-1:0]    adj;
        logic signed [SUM_W-1:0]    q;
        logic [SUM_W-COORD_BITS:0]  hi;
        adj = num[SUM_W-1] ? SUM_W'(HALF - 1) : SUM_W'(HALF);
        q   = (num + adj) >>> rvp_pkg::TRIG_FRAC_BITS;
        hi  = q[SUM_W-1:COORD_BITS-1];
        if ((&hi) || (~|hi))
            return q[COORD_BITS-1:0];
        else if (q[SUM_W-1])
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            return {1'b0, {(COORD_BITS-1){1'b1}}};
    endfunction

    logic                         v1_reg, v2_reg, v3_reg;
    logic                         adv1, adv2, adv3;
    logic signed [COORD_BITS-1:0] vx1_reg, vy1_reg;
    logic                         first1_reg, first2_reg, first3_reg;
    logic signed [PROD_W-1:0]     cdx_reg, sdy_reg, sdx_reg, cdy_reg;
    logic signed [PROD_W-1:0]     cdx_next, sdy_next, sdx_next, cdy_next;
    logic signed [COORD_BITS-1:0] rx_reg, ry_reg, rx_next, ry_next;
    logic signed [DIFF_W-1:0]     dx, dy;
    logic signed [PROD_W-1:0]     dx_e, dy_e, sin_e, cos_e;
    logic signed [rvp_pkg::TRIG_W-1:0] sin_c, cos_c;
    logic signed [SUM_W-1:0]      sum_x, sum_y;
    logic signed [SUM_W-1:0]      piv_x_term, piv_y_term;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign sin_c = trig.sin_q;
    assign cos_c = trig.cos_q;

    always_comb
    begin
        dx       = DIFF_W'(vx1_reg) - DIFF_W'(pivot_x);
        dy       = DIFF_W'(vy1_reg) - DIFF_W'(pivot_y);
        dx_e     = PROD_W'(dx);
        dy_e     = PROD_W'(dy);
        sin_e    = PROD_W'(sin_c);
        cos_e    = PROD_W'(cos_c);
        cdx_next = cos_e * dx_e;
        sdy_next = sin_e * dy_e;
        sdx_next = sin_e * dx_e;
        cdy_next = cos_e * dy_e;
    end

    always_comb
    begin
        piv_x_term = SUM_W'(pivot_x) <<< rvp_pkg::TRIG_FRAC_BITS;
        piv_y_term = SUM_W'(pivot_y) <<< rvp_pkg::TRIG_FRAC_BITS;
        sum_x      = SUM_W'(cdx_reg) - SUM_W'(sdy_reg) + piv_x_term;
        sum_y      = SUM_W'(sdx_reg) + SUM_W'(cdy_reg) + piv_y_term;
        rx_next    = round_sat(sum_x);
        ry_next    = round_sat(sum_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            vx1_reg    <= vertex_x;
            vy1_reg    <= vertex_y;
            first1_reg <= first_in;
        end
        if (adv2 && v1_reg)
        begin
            cdx_reg    <= cdx_next;
            sdy_reg    <= sdy_next;
            sdx_reg    <= sdx_next;
            cdy_reg    <= cdy_next;
            first2_reg <= first1_reg;
        end
        if (adv3 && v2_reg)
        begin
            rx_reg     <= rx_next;
            ry_reg     <= ry_next;
            first3_reg <= first2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign rot_x     = rx_reg;
    assign rot_y     = ry_reg;
    assign first_out = first3_reg;

endmodule

// ===== rtl/rvp_checker.sv =====
module rvp_assertions #(
    parameter int COORD_BITS = 16
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((6*COORD_BITS+7)/8)*8-1:0]      m_tdata
);

    logic signed [COORD_BITS-1:0] rx, ry, left_e, top_e, right_e, bottom_e;

    assign rx       = m_tdata[COORD_BITS-1:0];
    assign ry       = m_tdata[2*COORD_BITS-1:COORD_BITS];
    assign left_e   = m_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign top_e    = m_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign right_e  = m_tdata[5*COORD_BITS-1:4*COORD_BITS];
    assign bottom_e = m_tdata[6*COORD_BITS-1:5*COORD_BITS];

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output result changed while stalled");

    // The reported box always contains the point it is reported with.
    a_box_holds_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (left_e <= rx) && (rx <= right_e) && (top_e <= ry) && (ry <= bottom_e))
        else $error("bounding box does not contain the rotated point");

    // With a free output register the pipeline always takes a new vertex.
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although the output can drain");

    // With the receiver ready, an accepted vertex reaches the output without waiting.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing four cycles after input transaction");

endmodule

bind rotate_vertices_about_pivot_top rvp_assertions #(
    .COORD_BITS (COORD_BITS)
) u_rvp_assertions (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/rvp_checker.sv =====
`timescale 1ns / 100ps

// Watches the configuration port and both stream channels of the rotation block.
// It keeps its own copy of the angle, the pivot and the bounding box, predicts every
// result, and compares each output transaction with the oldest prediction.
module rvp_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [rvp_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [((COORD_BITS > 9) ? COORD_BITS : 9)-1:0] cfg_data,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic [0:0]                             s_tuser,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    output int                                     mismatches,
    output int                                     outstanding
);

    localparam int FRAC      = 14;
    localparam int DEG_FULL  = 360;
    localparam int DEG_RIGHT = 90;
    localparam int DEG_HALF  = 180;
    localparam longint unsigned PI_FIXED = 64'h3243F6A8885A308D;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Laid out like m_tdata: the first member sits in the highest bits.
    typedef struct packed {
        coord_t bottom_e;
        coord_t right_e;
        coord_t top_e;
        coord_t left_e;
        coord_t rot_y;
        coord_t rot_x;
    } placed_vertex_t;

    logic [rvp_pkg::ANGLE_W-1:0] turn_deg = '0;
    coord_t             piv_x    = '0;
    coord_t             piv_y    = '0;
    coord_t             box_lo_x = '0;
    coord_t             box_lo_y = '0;
    coord_t             box_hi_x = '0;
    coord_t             box_hi_y = '0;
    placed_vertex_t     rotated_due [$];
    int                 results_seen = 0;

    // (a * b) >> 60 on unsigned Q4.60 operands.
    function automatic longint unsigned q60_mul(input longint unsigned a, input longint unsigned b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // sin(deg) in Q2.14 for deg in 0..90 by a Taylor series, rounded half up.
    function automatic longint sine_q14(input int unsigned deg);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        int              k;
        x    = 64'(deg) * (PI_FIXED / 64'(DEG_HALF));
        x2   = q60_mul(x, x);
        term = x;
        acc  = x;
        for (k = 1; k <= 12; k++)
        begin
            term = q60_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2 == 1)
                acc -= term;
            else
                acc += term;
        end
        acc += 64'd1 << (59 - FRAC);
        return longint'(acc >> (60 - FRAC));
    endfunction

    function automatic coord_t round_clamp(input longint num);
        longint half;
        longint r;
        half = longint'(1) <<< (FRAC - 1);
        if (num >= 0)
            r = (num + half) >>> FRAC;
        else
            r = -((-num + half) >>> FRAC);
        if (r > COORD_MAX)
            r = COORD_MAX;
        if (r < COORD_MIN)
            r = COORD_MIN;
        return r[COORD_BITS-1:0];
    endfunction

    function automatic void rotate_about_pivot(input coord_t vx, input coord_t vy,
                                               output coord_t rx, output coord_t ry);
        int unsigned a;
        int unsigned quadrant;
        int unsigned rem;
        longint      sr;
        longint      cr;
        longint      s;
        longint      c;
        longint      dx;
        longint      dy;
        a = 32'(turn_deg);
        if (a >= DEG_FULL)
            a -= DEG_FULL;
        quadrant = a / DEG_RIGHT;
        rem      = a % DEG_RIGHT;
        sr = sine_q14(rem);
        cr = sine_q14(DEG_RIGHT - rem);
        case (quadrant)
            0:
            begin
                s = sr;
                c = cr;
            end
            1:
            begin
                s = cr;
                c = -sr;
            end
            2:
            begin
                s = -sr;
                c = -cr;
            end
            default:
            begin
                s = -cr;
                c = sr;
            end
        endcase
        dx = longint'(vx) - longint'(piv_x);
        dy = longint'(vy) - longint'(piv_y);
        rx = round_clamp(c * dx - s * dy + (longint'(piv_x) <<< FRAC));
        ry = round_clamp(s * dx + c * dy + (longint'(piv_y) <<< FRAC));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int seq, input coord_t want,
                               input coord_t got);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                      seq, name, want, got));
    endtask

    always @(posedge clk)
    begin
        placed_vertex_t want;
        placed_vertex_t got;
        coord_t         rx;
        coord_t         ry;
        if (!rst_n)
        begin
            turn_deg = '0;
            piv_x    = '0;
            piv_y    = '0;
            box_lo_x = '0;
            box_lo_y = '0;
            box_hi_x = '0;
            box_hi_y = '0;
            rotated_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    rvp_pkg::REG_ANGLE:   turn_deg = cfg_data[rvp_pkg::ANGLE_W-1:0];
                    rvp_pkg::REG_PIVOT_X: piv_x    = cfg_data[COORD_BITS-1:0];
                    rvp_pkg::REG_PIVOT_Y: piv_y    = cfg_data[COORD_BITS-1:0];
                    default:              ;
                endcase
            end

            // The output side is checked before this edge's input is predicted.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[6*COORD_BITS-1:0];
                if (rotated_due.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                else
                begin
                    want = rotated_due.pop_front();
                    check_field("rotated_x",   results_seen, want.rot_x,    got.rot_x);
                    check_field("rotated_y",   results_seen, want.rot_y,    got.rot_y);
                    check_field("left_edge",   results_seen, want.left_e,   got.left_e);
                    check_field("top_edge",    results_seen, want.top_e,    got.top_e);
                    check_field("right_edge",  results_seen, want.right_e,  got.right_e);
                    check_field("bottom_edge", results_seen, want.bottom_e, got.bottom_e);
                end
                results_seen++;
            end

            if (s_tvalid && s_tready)
            begin
                rotate_about_pivot(s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS],
                                   rx, ry);
                if (s_tuser[0])
                begin
                    box_lo_x = rx;
                    box_hi_x = rx;
                    box_lo_y = ry;
                    box_hi_y = ry;
                end
                else
                begin
                    if (rx < box_lo_x)
                        box_lo_x = rx;
                    if (rx > box_hi_x)
                        box_hi_x = rx;
                    if (ry < box_lo_y)
                        box_lo_y = ry;
                    if (ry > box_hi_y)
                        box_hi_y = ry;
                end
                want.rot_x    = rx;
                want.rot_y    = ry;
                want.left_e   = box_lo_x;
                want.top_e    = box_lo_y;
                want.right_e  = box_hi_x;
                want.bottom_e = box_hi_y;
                rotated_due.push_back(want);
            end
            outstanding <= rotated_due.size();
        end
    end

endmodule

// ===== tb/tb_rotate_vertices_about_pivot_top.sv =====
`timescale 1ns / 100ps

module tb_rotate_vertices_about_pivot_top;

    localparam int COORD_BITS   = 16;
    localparam int CFG_W        = (COORD_BITS > 9) ? COORD_BITS : 9;
    localparam int S_W          = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_W          = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int ANGLE_W      = rvp_pkg::ANGLE_W;
    localparam int RANDOM_ITEMS = 640;
    localparam int CALM_ITEMS   = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // Index 3 is not a register; writes there must change nothing.
    localparam logic [rvp_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           cfg_we   = 1'b0;
    logic [rvp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]               cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic [S_W-1:0]                 s_tdata  = '0;
    logic [0:0]                     s_tuser  = '0;
    logic                           m_tready = 1'b0;
    wire                            s_tready;
    wire                            m_tvalid;
    wire  [M_W-1:0]                 m_tdata;

    int mismatches;
    int outstanding;
    int cycles    = 0;
    // Percent chance of an idle burst before a vertex and of a stall burst on the
    // result side. Both change from phase to phase; calm switches them off.
    int gap_pct   = 0;
    int stall_pct = 0;
    bit calm      = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rotate_vertices_about_pivot_top #(
        .COORD_BITS (COORD_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rvp_checker #(
        .COORD_BITS (COORD_BITS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // The limit is far above the slowest legal run: every vertex waiting out a full
    // idle burst, a full stall burst and the trip through the pipeline.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: m_tready is driven in ready runs and stall bursts, chosen at random.
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(13, 1)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(8, 1)) @(posedge clk);
            end
        end
    end

    // All tasks below are entered just after a rising edge and return just after one.

    // The caller lowers cfg_we once the last register has been written.
    task automatic write_reg(input logic [rvp_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // The angle field is nine bits wide; the bits above it carry noise that the
    // block has to drop.
    task automatic program_rotation(input logic [ANGLE_W-1:0] angle, input coord_t px,
                                    input coord_t py);
        write_reg(rvp_pkg::REG_ANGLE, CFG_W'({7'($urandom_range(127)), angle}));
        write_reg(rvp_pkg::REG_PIVOT_X, px);
        write_reg(rvp_pkg::REG_PIVOT_Y, py);
        cfg_we <= 1'b0;
    endtask

    // Holds off the sender until every predicted result has been taken. The first
    // edge lets a transaction accepted at the current edge show up in the count.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One vertex transaction, optionally preceded by an idle burst with junk on the bus.
    task automatic send_vertex(input coord_t x, input coord_t y, input logic first);
        if (!calm && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_W'($urandom);
            s_tuser  <= 1'($urandom_range(1));
            repeat ($urandom_range(13, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({y, x});
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic coord_t edge_value();
        case ($urandom_range(6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return ANGLE_W'($urandom_range(359));
        else if (roll < 80)
            return ANGLE_W'($urandom_range(511, 360));
        case ($urandom_range(4))
            0:       return 0;
            1:       return 90;
            2:       return 180;
            3:       return 270;
            default: return 359;
        endcase
    endfunction

    function automatic coord_t pick_pivot();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return coord_t'($urandom_range(2000) - 1000);
        else if (roll < 80)
            return coord_t'($urandom);
        return edge_value();
    endfunction

    // Most vertices sit around the pivot so that shapes stay inside the coordinate
    // range; the rest are anywhere, or on the extremes, and exercise saturation.
    function automatic coord_t pick_vertex(input coord_t around);
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return coord_t'(around + $urandom_range(6000) - 3000);
        else if (roll < 85)
            return coord_t'($urandom);
        return edge_value();
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 12;
            default: return 40;
        endcase
    endfunction

    initial
    begin
        int     sent;
        int     seg_left;
        int     shape_len;
        int     i;
        logic   first;
        coord_t px;
        coord_t py;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with light idling on both sides.
        gap_pct   = 12;
        stall_pct = 12;

        // No shape start after reset: the box grows out of the reset box at the origin.
        // The angle and pivot are still at their reset values.
        send_vertex(100, -50, 1'b0);
        send_vertex(123, 45, 1'b0);

        // 45 degrees about the origin: corners of the range push results past it.
        settle();
        write_reg(REG_SPARE, '1);
        program_rotation(45, 0, 0);
        send_vertex(32767, 32767, 1'b1);
        send_vertex(-32768, -32768, 1'b0);
        send_vertex(32767, -32768, 1'b0);
        send_vertex(-32768, 32767, 1'b0);

        // An angle above a full turn, with the pivot in a far corner.
        settle();
        program_rotation(511, -32768, 32767);
        send_vertex(32767, -32768, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(-1, -1, 1'b0);

        // Largest in-range angle, pivot in the opposite corner.
        settle();
        program_rotation(359, 32767, -32768);
        send_vertex(-32768, 32767, 1'b1);
        send_vertex(1, -1, 1'b0);

        // Quadrant boundaries.
        settle();
        program_rotation(90, 1000, -1000);
        send_vertex(0, 0, 1'b1);
        send_vertex(5, 7, 1'b0);
        settle();
        program_rotation(180, 0, 0);
        send_vertex(0, 0, 1'b1);
        send_vertex(-32768, 0, 1'b0);
        settle();
        program_rotation(270, -3, 2);
        send_vertex(3, 4, 1'b1);
        send_vertex(32767, -32768, 1'b0);

        // Exactly one full turn folds back to zero.
        settle();
        program_rotation(360, 7, -9);
        send_vertex(-7, 9, 1'b1);

        // Random part: phases of shapes under one setting each. Every phase starts
        // with the sender held off until the pipeline has emptied.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            px = pick_pivot();
            py = pick_pivot();
            program_rotation(pick_angle(), px, py);
            gap_pct   = pick_idle_pct();
            stall_pct = pick_idle_pct();
            calm      = (sent >= RANDOM_ITEMS - CALM_ITEMS);
            seg_left  = $urandom_range(60, 20);
            while (seg_left > 0 && sent < RANDOM_ITEMS)
            begin
                shape_len = $urandom_range(10, 1);
                for (i = 0; i < shape_len; i++)
                begin
                    // Well-formed shapes mostly; now and then a stray flag.
                    first = (i == 0);
                    if ($urandom_range(99) < 10)
                        first = 1'($urandom_range(1));
                    send_vertex(pick_vertex(px), pick_vertex(py), first);
                    sent++;
                    seg_left--;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rvp_pkg.sv
rtl/rvp_rotate.sv
rtl/rotate_vertices_about_pivot_top.sv
rtl/rvp_checker.sv
tb/rvp_checker.sv
tb/tb_rotate_vertices_about_pivot_top.sv
